>>> sv/eip_pkg.sv
package eip_pkg;

   // frame layout and header checks
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IHL_MASK       = 8'h0F;
   localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
   localparam logic [15:0] MIN_IPV4_FRAME = 16'd34;
   localparam logic [5:0]  MIN_IP_HDR     = 6'd20;
   localparam logic [15:0] BYTE_INDEX_MAX = 16'hFFFF;

   // byte positions inside the frame
   localparam logic [15:0] POS_ETYPE_HI = 16'd12;
   localparam logic [15:0] POS_ETYPE_LO = 16'd13;
   localparam logic [15:0] POS_IHL      = 16'd14;
   localparam logic [15:0] POS_TLEN_HI  = 16'd16;
   localparam logic [15:0] POS_TLEN_LO  = 16'd17;
   localparam logic [15:0] POS_PROTO    = 16'd23;
   localparam logic [15:0] POS_SRC_LO   = 16'd26;
   localparam logic [15:0] POS_SRC_HI   = 16'd29;
   localparam logic [15:0] POS_DST_LO   = 16'd30;
   localparam logic [15:0] POS_DST_HI   = 16'd33;

   // protocol numbers and classes
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;
   localparam logic [1:0] CLASS_OTHER = 2'd0;
   localparam logic [1:0] CLASS_TCP   = 2'd1;
   localparam logic [1:0] CLASS_UDP   = 2'd2;
   localparam logic [1:0] CLASS_ICMP  = 2'd3;

   localparam int DEFAULT_QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        is_ipv4;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [7:0]  ip_protocol;
      logic [1:0]  proto_class;
      logic [15:0] payload_bytes;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic        ports_valid;
      logic [15:0] frame_bytes;
      logic [31:0] ipv4_total;
      logic [31:0] other_total;
   } rsp_type;

   // captured header of one finished frame
   typedef struct packed {
      logic [15:0] frame_len;
      logic [15:0] ether_type;
      logic [3:0]  header_words;
      logic [15:0] ip_len;
      logic [7:0]  proto;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] l4_src;
      logic [15:0] l4_dst;
   } rec_type;

   // queue handshake between front and back
   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

endpackage

>>> sv/eip_front.sv
module eip_front
   import eip_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    q_full,
   output logic    push,
   output rec_type push_data
);

   logic [15:0] byte_index_ff, byte_index_in;
   rec_type     hdr_ff, hdr_in;
   rec_type     cap;
   logic        accept;
   logic [15:0] base;
   logic [7:0]  b;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.byte_value;
   assign base      = ETH_HDR_LEN + {10'd0, hdr_ff.header_words, 2'b00};

   // capture this beat into the header fields
   always_comb begin
      cap           = hdr_ff;
      byte_index_in = byte_index_ff;
      cap.frame_len = byte_index_ff;
      if (byte_index_ff != BYTE_INDEX_MAX) begin
         byte_index_in = byte_index_ff + 16'd1;
         cap.frame_len = byte_index_in;
         if (byte_index_ff == POS_ETYPE_HI) begin
            cap.ether_type[15:8] = b;
         end else if (byte_index_ff == POS_ETYPE_LO) begin
            cap.ether_type[7:0] = b;
         end else if (byte_index_ff == POS_IHL) begin
            cap.header_words = b[3:0] & IHL_MASK[3:0];
         end else if (byte_index_ff == POS_TLEN_HI) begin
            cap.ip_len[15:8] = b;
         end else if (byte_index_ff == POS_TLEN_LO) begin
            cap.ip_len[7:0] = b;
         end else if (byte_index_ff == POS_PROTO) begin
            cap.proto = b;
         end else if (byte_index_ff >= POS_SRC_LO && byte_index_ff <= POS_SRC_HI) begin
            cap.src_addr = {hdr_ff.src_addr[23:0], b};
         end else if (byte_index_ff >= POS_DST_LO && byte_index_ff <= POS_DST_HI) begin
            cap.dst_addr = {hdr_ff.dst_addr[23:0], b};
         end
         // port window starts after the ip header, never inside it
         if (byte_index_ff >= MIN_IPV4_FRAME) begin
            if (byte_index_ff == base) begin
               cap.l4_src[15:8] = b;
            end else if (byte_index_ff == base + 16'd1) begin
               cap.l4_src[7:0] = b;
            end else if (byte_index_ff == base + 16'd2) begin
               cap.l4_dst[15:8] = b;
            end else if (byte_index_ff == base + 16'd3) begin
               cap.l4_dst[7:0] = b;
            end
         end
      end
   end

   // hand the frame to the queue on its last beat and start over
   always_comb begin
      push      = accept && req_data.last_byte;
      push_data = cap;
      hdr_in    = hdr_ff;
      if (accept) begin
         hdr_in = cap;
         if (req_data.last_byte) begin
            hdr_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         hdr_ff        <= '0;
      end else if (accept) begin
         byte_index_ff <= req_data.last_byte ? 16'd0 : byte_index_in;
         hdr_ff        <= hdr_in;
      end
   end

endmodule

>>> sv/eip_queue.sv
module eip_queue
   import eip_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rec_type      push_data,
   input  logic         pop,
   output rec_type      pop_data,
   output q_status_type status
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

   rec_type       mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign status.full      = (count_ff == FULL_CNT);
   assign status.not_empty = (count_ff != '0);
   assign do_push  = push && !status.full;
   assign do_pop   = pop && status.not_empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/eip_back.sv
module eip_back
   import eip_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  q_status_type status,
   input  rec_type      rec,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] ipv4_cnt_ff, ipv4_cnt_in;
   logic [31:0] other_cnt_ff, other_cnt_in;
   logic [5:0]  hl;
   logic [15:0] hdr_end;
   logic        valid;
   logic        tcpudp;
   logic        ports_here;
   logic [1:0]  cls;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pop       = status.not_empty && (!rsp_valid_ff || rsp_ready);

   // header checks
   assign hl         = {rec.header_words, 2'b00};
   assign hdr_end    = ETH_HDR_LEN + {10'd0, hl};
   assign valid      = rec.frame_len >= ETH_HDR_LEN && rec.ether_type == ETHERTYPE_IPV4 &&
                       rec.frame_len >= MIN_IPV4_FRAME && hl >= MIN_IP_HDR &&
                       rec.frame_len >= hdr_end;
   assign ports_here = rec.frame_len >= hdr_end + 16'd4;

   // protocol class
   always_comb begin
      case (rec.proto)
         PROTO_TCP: begin
            cls    = CLASS_TCP;
            tcpudp = 1'b1;
         end
         PROTO_UDP: begin
            cls    = CLASS_UDP;
            tcpudp = 1'b1;
         end
         PROTO_ICMP: begin
            cls    = CLASS_ICMP;
            tcpudp = 1'b0;
         end
         default: begin
            cls    = CLASS_OTHER;
            tcpudp = 1'b0;
         end
      endcase
   end

   // result assembly and running totals
   always_comb begin
      ipv4_cnt_in  = ipv4_cnt_ff;
      other_cnt_in = other_cnt_ff;
      rsp_in       = '0;
      if (valid) begin
         ipv4_cnt_in           = ipv4_cnt_ff + 32'd1;
         rsp_in.is_ipv4        = 1'b1;
         rsp_in.source_address = rec.src_addr;
         rsp_in.dest_address   = rec.dst_addr;
         rsp_in.ip_protocol    = rec.proto;
         rsp_in.proto_class    = cls;
         rsp_in.payload_bytes  = (rec.ip_len >= {10'd0, hl}) ?
                                 rec.ip_len - {10'd0, hl} : 16'd0;
         if (tcpudp && ports_here) begin
            rsp_in.source_port = rec.l4_src;
            rsp_in.dest_port   = rec.l4_dst;
            rsp_in.ports_valid = (rec.l4_src != 16'd0) && (rec.l4_dst != 16'd0);
         end
      end else begin
         other_cnt_in = other_cnt_ff + 32'd1;
      end
      rsp_in.frame_bytes = rec.frame_len;
      rsp_in.ipv4_total  = ipv4_cnt_in;
      rsp_in.other_total = other_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         ipv4_cnt_ff  <= '0;
         other_cnt_ff <= '0;
      end else begin
         if (pop) begin
            rsp_valid_ff <= 1'b1;
            ipv4_cnt_ff  <= ipv4_cnt_in;
            other_cnt_ff <= other_cnt_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // output beat register
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> sv/ethernet_ipv4_header_parser.sv
// Ethernet/IPv4 header parser. Frame bytes enter one per beat on req_ (byte_value with
// last_byte on the final byte) and the block takes one byte every cycle while the queue
// is not full. The front part captures the header fields as the bytes stream by; on the
// last byte it pushes the captured header into a small queue (QUEUE_DEPTH entries) and
// starts over for the next frame. The back part checks the header, classifies the protocol,
// updates the running totals and, on popping the queue, places one result beat in an output
// register; frames stay queued while earlier results still wait on rsp_. req_ready drops
// only while the queue is full, that is when results are not taken on rsp_ and frames keep
// ending; a result waiting in the output register does not stop bytes from coming in.
module ethernet_ipv4_header_parser
   import eip_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic         push;
   logic         pop;
   rec_type      push_data;
   rec_type      pop_data;
   q_status_type q_status;

   // byte capture
   eip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_status.full),
      .push      (push),
      .push_data (push_data)
   );

   // finished frames waiting for the back part
   eip_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // checks, totals and result beat
   eip_back u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (q_status),
      .rec       (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // rejected frames carry only length and totals
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_ipv4 |->
         rsp_data.source_address == 32'd0 && rsp_data.payload_bytes == 16'd0 &&
         !rsp_data.ports_valid)
   else $error("rejected frame carries header fields");

   // valid ports only for tcp or udp with nonzero ports
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ports_valid |->
         rsp_data.is_ipv4 &&
         (rsp_data.proto_class == CLASS_TCP || rsp_data.proto_class == CLASS_UDP) &&
         rsp_data.source_port != 16'd0 && rsp_data.dest_port != 16'd0)
   else $error("ports_valid without tcp or udp ports");

   // each new beat right after a taken one advances the totals by exactly one frame
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(rsp_valid && rsp_ready) && rsp_valid |->
         32'(rsp_data.ipv4_total + rsp_data.other_total) ==
         32'($past(rsp_data.ipv4_total + rsp_data.other_total) + 32'd1))
   else $error("running totals skipped or repeated a frame");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(rsp_valid && !rsp_ready) |-> rsp_valid && $stable(rsp_data))
   else $error("result beat changed while stalled");

endmodule
